// ===== sv/asgr_pkg.sv =====
package asgr_pkg;

  // Fixed limits of the markup generator
  localparam int unsigned PaletteSize = 256;
  localparam int unsigned MaxDepth    = 255;

  localparam logic [9:0] PALETTE_LIMIT = 10'(PaletteSize);
  localparam logic [7:0] DEPTH_LIMIT   = 8'(MaxDepth);

  // Reset values of the configuration registers
  localparam logic [7:0] ESCAPE_RESET  = 8'd27;
  localparam logic [7:0] LITERAL_RESET = 8'd127;

  // Configuration register indexes
  localparam logic CFG_ESCAPE  = 1'b0;
  localparam logic CFG_LITERAL = 1'b1;

  // Parse modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_CSI    = 3'd2;
  localparam logic [2:0] MODE_FIVE   = 3'd3;
  localparam logic [2:0] MODE_SEP    = 3'd4;
  localparam logic [2:0] MODE_COLOR  = 3'd5;

  // Token kinds
  localparam logic [3:0] KIND_LITERAL = 4'd0;
  localparam logic [3:0] KIND_ENTITY  = 4'd1;
  localparam logic [3:0] KIND_NUMREF  = 4'd2;
  localparam logic [3:0] KIND_STYLE   = 4'd3;
  localparam logic [3:0] KIND_COLOR   = 4'd4;
  localparam logic [3:0] KIND_CLOSE   = 4'd5;
  localparam logic [3:0] KIND_UNKNOWN = 4'd6;
  localparam logic [3:0] KIND_UNSUPP  = 4'd7;
  localparam logic [3:0] KIND_COLERR  = 4'd8;

  // Entity codes
  localparam logic [2:0] ENT_QUOT = 3'd0;
  localparam logic [2:0] ENT_APOS = 3'd1;
  localparam logic [2:0] ENT_AMP  = 3'd2;
  localparam logic [2:0] ENT_LT   = 3'd3;
  localparam logic [2:0] ENT_GT   = 3'd4;

  // Style codes
  localparam logic [2:0] STY_BOLD    = 3'd0;
  localparam logic [2:0] STY_LIGHTER = 3'd1;
  localparam logic [2:0] STY_ITALIC  = 3'd2;
  localparam logic [2:0] STY_ULINE   = 3'd3;
  localparam logic [2:0] STY_BLINK   = 3'd4;
  localparam logic [2:0] STY_STRIKE  = 3'd5;

  // Characters the parser looks at
  localparam logic [20:0] CH_QUOT   = 21'd34;
  localparam logic [20:0] CH_AMP    = 21'd38;
  localparam logic [20:0] CH_APOS   = 21'd39;
  localparam logic [20:0] CH_ZERO   = 21'd48;
  localparam logic [20:0] CH_FIVE   = 21'd53;
  localparam logic [20:0] CH_NINE   = 21'd57;
  localparam logic [20:0] CH_SEMI   = 21'd59;
  localparam logic [20:0] CH_LT     = 21'd60;
  localparam logic [20:0] CH_GT     = 21'd62;
  localparam logic [20:0] CH_LBRACK = 21'd91;
  localparam logic [20:0] CH_H      = 21'd104;
  localparam logic [20:0] CH_L      = 21'd108;
  localparam logic [20:0] CH_M      = 21'd109;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] param;
    logic [8:0] palette;
    logic       ext_bg;
    logic [7:0] depth;
  } asgr_state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [20:0] char_code;
    logic [2:0]  entity;
    logic [2:0]  style;
    logic [7:0]  color_index;
    logic        is_background;
    logic        is_bright;
    logic        is_extended;
    logic [7:0]  close_count;
  } asgr_token_t;

endpackage

// ===== sv/ansi_sgr_to_markup_tokens_top.sv =====
// Path: an accepted input beat is held in the input register, parsed by the combinational
//   step, and its token is registered in the output register, from which it can leave.
// Throughput: one item per cycle; the combinational parse step between the input
//   and output registers sets it, and stalls only come from out_stall.
// Reset (rst, synchronous): normal text mode, zero span depth, empty pipeline,
//   escape_code 27, literal_limit 127.
module ansi_sgr_to_markup_tokens_top import asgr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] code_point,
  input  logic        end_of_stream,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [20:0] char_code,
  output logic [2:0]  entity,
  output logic [2:0]  style,
  output logic [7:0]  color_index,
  output logic        is_background,
  output logic        is_bright,
  output logic        is_extended,
  output logic [7:0]  close_count
);

  logic [7:0]  escape_code;
  logic [7:0]  literal_limit;
  logic        hold_valid;
  logic [20:0] hold_cp;
  logic        hold_eos;
  asgr_state_t state;
  asgr_state_t state_next;
  logic        emit;
  asgr_token_t tok;
  asgr_token_t tok_q;
  logic        advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code   <= ESCAPE_RESET;
      literal_limit <= LITERAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ESCAPE:  escape_code   <= cfg_data;
        CFG_LITERAL: literal_limit <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Held beat moves on when the output register is free or draining
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_cp  <= code_point;
      hold_eos <= end_of_stream;
    end
  end

  asgr_step u_step (
    .cur           (state),
    .code_point    (hold_cp),
    .end_of_stream (hold_eos),
    .escape_code   (escape_code),
    .literal_limit (literal_limit),
    .nxt           (state_next),
    .emit          (emit),
    .tok           (tok)
  );

  // Parser state: mode, param, palette, ext_bg, depth
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= {MODE_NORMAL, 8'd0, 9'd0, 1'b0, 8'd0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      tok_q <= tok;
    end
  end

  assign kind          = tok_q.kind;
  assign char_code     = tok_q.char_code;
  assign entity        = tok_q.entity;
  assign style         = tok_q.style;
  assign color_index   = tok_q.color_index;
  assign is_background = tok_q.is_background;
  assign is_bright     = tok_q.is_bright;
  assign is_extended   = tok_q.is_extended;
  assign close_count   = tok_q.close_count;

endmodule

// ===== sv/asgr_step.sv =====
module asgr_step import asgr_pkg::*; (
  input  asgr_state_t cur,
  input  logic [20:0] code_point,
  input  logic        end_of_stream,
  input  logic [7:0]  escape_code,
  input  logic [7:0]  literal_limit,
  output asgr_state_t nxt,
  output logic        emit,
  output asgr_token_t tok
);

  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] param_acc;
  logic [12:0] pal_acc;
  logic        open_req;
  asgr_token_t open_tok;
  logic        is_m;
  logic [7:0]  a;

  // Decimal digit decode and saturating accumulators
  assign is_digit  = (code_point >= CH_ZERO) && (code_point <= CH_NINE);
  assign digit     = code_point[3:0];
  assign param_acc = {4'b0, cur.param} * 12'd10 + {8'b0, digit};
  assign pal_acc   = {4'b0, cur.palette} * 13'd10 + {9'b0, digit};
  assign is_m      = (code_point == CH_M);
  assign a         = cur.param;

  always_comb begin
    nxt      = cur;
    emit     = 1'b0;
    tok      = '0;
    open_req = 1'b0;
    open_tok = '0;

    if (end_of_stream) begin
      // flush: close everything, clear state
      nxt             = '0;
      nxt.mode        = MODE_NORMAL;
      emit            = 1'b1;
      tok.kind        = KIND_CLOSE;
      tok.close_count = cur.depth;
    end else if (cur.mode == MODE_FIVE || cur.mode == MODE_SEP) begin
      // 256-colour prefix: '5' then ';'
      if (code_point != ((cur.mode == MODE_FIVE) ? CH_FIVE : CH_SEMI)) begin
        nxt.mode      = MODE_NORMAL;
        emit          = 1'b1;
        tok.kind      = KIND_COLERR;
        tok.char_code = code_point;
      end else begin
        nxt.mode = (cur.mode == MODE_FIVE) ? MODE_SEP : MODE_COLOR;
      end
    end else if (cur.mode == MODE_COLOR) begin
      if (code_point == CH_SEMI || is_m) begin
        nxt.palette = '0;
        if ({1'b0, cur.palette} >= PALETTE_LIMIT) begin
          nxt.mode      = MODE_NORMAL;
          emit          = 1'b1;
          tok.kind      = KIND_COLERR;
          tok.char_code = code_point;
        end else begin
          nxt.mode               = is_m ? MODE_NORMAL : MODE_CSI;
          nxt.param              = '0;
          open_req               = 1'b1;
          open_tok.kind          = KIND_COLOR;
          open_tok.color_index   = cur.palette[7:0];
          open_tok.is_background = cur.ext_bg;
          open_tok.is_extended   = 1'b1;
        end
      end else if (!is_digit) begin
        nxt.palette   = '0;
        nxt.mode      = MODE_NORMAL;
        emit          = 1'b1;
        tok.kind      = KIND_COLERR;
        tok.char_code = code_point;
      end else begin
        nxt.palette = (pal_acc > 13'd511) ? 9'd511 : pal_acc[8:0];
      end
    end else if (code_point == {13'b0, escape_code}) begin
      // escape restarts the sequence
      nxt.mode  = MODE_ESC;
      nxt.param = '0;
    end else if (cur.mode == MODE_ESC) begin
      if (code_point == CH_LBRACK) begin
        nxt.mode = MODE_CSI;
      end else begin
        nxt.mode      = MODE_NORMAL;
        emit          = 1'b1;
        tok.kind      = KIND_UNKNOWN;
        tok.char_code = code_point;
      end
    end else if (cur.mode == MODE_CSI) begin
      if (code_point == CH_SEMI || is_m) begin
        // parameter finished: act on its value
        nxt.param = '0;
        nxt.mode  = is_m ? MODE_NORMAL : MODE_CSI;
        if (a == 8'd0) begin
          emit            = 1'b1;
          tok.kind        = KIND_CLOSE;
          tok.close_count = cur.depth;
          nxt.depth       = '0;
        end else if (a inside {[8'd1:8'd6], 8'd9}) begin
          open_req      = 1'b1;
          open_tok.kind = KIND_STYLE;
          case (a)
            8'd1:    open_tok.style = STY_BOLD;
            8'd2:    open_tok.style = STY_LIGHTER;
            8'd3:    open_tok.style = STY_ITALIC;
            8'd4:    open_tok.style = STY_ULINE;
            8'd9:    open_tok.style = STY_STRIKE;
            default: open_tok.style = STY_BLINK;
          endcase
        end else if (a inside {[8'd30:8'd37]}) begin
          open_req             = 1'b1;
          open_tok.kind        = KIND_COLOR;
          open_tok.color_index = a - 8'd30;
        end else if (a inside {[8'd40:8'd47]}) begin
          open_req               = 1'b1;
          open_tok.kind          = KIND_COLOR;
          open_tok.color_index   = a - 8'd40;
          open_tok.is_background = 1'b1;
        end else if (a inside {[8'd90:8'd97]}) begin
          open_req             = 1'b1;
          open_tok.kind        = KIND_COLOR;
          open_tok.color_index = a - 8'd90;
          open_tok.is_bright   = 1'b1;
        end else if (a inside {[8'd100:8'd107]}) begin
          open_req               = 1'b1;
          open_tok.kind          = KIND_COLOR;
          open_tok.color_index   = a - 8'd100;
          open_tok.is_background = 1'b1;
          open_tok.is_bright     = 1'b1;
        end else if ((a == 8'd38 || a == 8'd48) && !is_m) begin
          nxt.mode    = MODE_FIVE;
          nxt.ext_bg  = (a == 8'd48);
          nxt.palette = '0;
        end
      end else if (is_digit) begin
        nxt.param = (param_acc > 12'd255) ? 8'd255 : param_acc[7:0];
      end else if (code_point == CH_H || code_point == CH_L) begin
        nxt.mode      = MODE_NORMAL;
        emit          = 1'b1;
        tok.kind      = KIND_UNSUPP;
        tok.char_code = code_point;
      end
    end else begin
      // plain text; unused mode codes land here too
      nxt.mode = MODE_NORMAL;
      emit     = 1'b1;
      if (code_point == CH_QUOT || code_point == CH_APOS || code_point == CH_AMP ||
          code_point == CH_LT || code_point == CH_GT) begin
        tok.kind = KIND_ENTITY;
        if (code_point == CH_QUOT)      tok.entity = ENT_QUOT;
        else if (code_point == CH_APOS) tok.entity = ENT_APOS;
        else if (code_point == CH_AMP)  tok.entity = ENT_AMP;
        else if (code_point == CH_LT)   tok.entity = ENT_LT;
        else                            tok.entity = ENT_GT;
      end else begin
        tok.kind      = (code_point <= {13'b0, literal_limit}) ? KIND_LITERAL : KIND_NUMREF;
        tok.char_code = code_point;
      end
    end

    // span open, dropped silently when the depth is full
    if (open_req && cur.depth < DEPTH_LIMIT) begin
      emit      = 1'b1;
      tok       = open_tok;
      nxt.depth = cur.depth + 8'd1;
    end
  end

endmodule

// ===== sv/asgr_checker.sv =====
module asgr_checker import asgr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  kind,
  input logic [2:0]  entity,
  input logic [20:0] char_code,
  input logic [7:0]  color_index,
  input logic        is_extended
);

  // a stalled beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(char_code))
    else $error("output beat changed under stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // entity tokens carry a known entity and no character
  a_entity: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ENTITY |-> entity <= ENT_GT && char_code == 21'd0)
    else $error("bad entity token");

  // basic palette colours stay in the eight-entry range
  a_basic_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_COLOR && !is_extended |-> color_index < 8'd8)
    else $error("basic colour index out of range");

endmodule

bind ansi_sgr_to_markup_tokens_top asgr_checker u_asgr_checker (.*);
